>>> src/assert_macros.svh
// assertion helpers for the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> src/ptts_pkg.sv
package ptts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = ($clog2(NUM_SLOTS) > 3) ? $clog2(NUM_SLOTS) : 3;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_SUSPEND = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;

    localparam logic [2:0] ST_DUE     = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_CREATED = 3'd2;
    localparam logic [2:0] ST_TAKEN   = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    typedef struct packed {
        logic        apply;
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [15:0] delay;
    } t_cmd;

    typedef struct packed {
        logic tok;
        logic fire;
        logic hit;
        logic occ_hit;
    } t_cell_stat;

endpackage

>>> src/ptts_in_if.sv
interface ptts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [2:0]  task_slot;
    logic [15:0] period_ticks;
    logic [15:0] initial_delay;

    modport source (output valid, op, task_slot, period_ticks, initial_delay, input ready);
    modport sink   (input valid, op, task_slot, period_ticks, initial_delay, output ready);
endinterface

>>> src/ptts_out_if.sv
interface ptts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] fired_slot;
    logic       last_result;

    modport source (output valid, status, fired_slot, last_result, input ready);
    modport sink   (input valid, status, fired_slot, last_result, output ready);
endinterface

>>> src/ptts_cell.sv
module ptts_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ptts_pkg::IDX_W-1:0] i_index,
    input  ptts_pkg::t_cmd           i_cmd,
    input  logic                     i_tok,
    input  logic                     i_shift,
    input  logic                     i_step,
    output ptts_pkg::t_cell_stat     o_stat
);
    import ptts_pkg::*;

    logic        r_tok, n_tok;
    logic        r_occ, n_occ;
    logic        r_susp, n_susp;
    logic [15:0] r_period, n_period;
    logic [15:0] r_cd, n_cd;
    logic        sel;
    logic        visit;

    assign sel   = i_cmd.apply && (IDX_W'(i_cmd.slot) == i_index);
    assign visit = r_tok && i_step;

    always_comb begin
        n_tok    = i_shift ? i_tok : r_tok;
        n_occ    = r_occ;
        n_susp   = r_susp;
        n_period = r_period;
        n_cd     = r_cd;
        if (sel) begin
            case (i_cmd.op)
                OP_CREATE: begin
                    if (!r_occ) begin
                        n_occ    = 1'b1;
                        n_susp   = 1'b0;
                        n_period = i_cmd.period;
                        n_cd     = i_cmd.delay;
                    end
                end
                OP_DELETE:  n_occ  = 1'b0;
                OP_SUSPEND: n_susp = 1'b1;
                OP_RESUME:  n_susp = 1'b0;
                default: ;
            endcase
        end else if (visit && !r_susp) begin
            if (r_cd != 16'd0) begin
                n_cd = r_cd - 16'd1;
            end else if (r_occ) begin
                n_cd = r_period - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_occ    <= 1'b0;
            r_susp   <= 1'b0;
            r_period <= 16'd0;
            r_cd     <= 16'd0;
        end else begin
            r_tok    <= n_tok;
            r_occ    <= n_occ;
            r_susp   <= n_susp;
            r_period <= n_period;
            r_cd     <= n_cd;
        end
    end

    assign o_stat.tok     = r_tok;
    assign o_stat.fire    = r_tok && !r_susp && (r_cd == 16'd0) && r_occ;
    assign o_stat.hit     = sel;
    assign o_stat.occ_hit = sel && r_occ;

endmodule

>>> src/periodic_task_tick_scheduler_core.sv
// create, delete, suspend, resume and spare opcodes: one beat out, in the cycle after acceptance
// tick: a visit token walks the slot cells one per cycle while the sink keeps up;
// a due beat waiting on the sink stalls the walk
// one item at a time; the next item is taken once the last result is registered
// reset (synchronous, active low) empties all slots and clears countdowns
`include "assert_macros.svh"

module periodic_task_tick_scheduler_core (
    input logic      i_clk,
    input logic      i_rst_n,
    ptts_in_if.sink  i_in,
    ptts_out_if.source o_out
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_TICK, S_FLUSH} t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_idx;
    logic               r_pend;
    logic [2:0]         r_pend_slot;
    logic               r_out_valid;
    logic [2:0]         r_status;
    logic [2:0]         r_fired_slot;
    logic               r_last;

    t_cmd               cmd;
    t_cell_stat         stat [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] tok_vec, fire_vec, hit_vec, occ_vec;
    logic               out_free;
    logic               in_acc;
    logic               start;
    logic               fire_any;
    logic               step;
    logic               beat_load;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign start      = in_acc && (i_in.op == OP_TICK);

    assign cmd.apply  = in_acc && (i_in.op != OP_TICK);
    assign cmd.op     = i_in.op;
    assign cmd.slot   = i_in.task_slot;
    assign cmd.period = i_in.period_ticks;
    assign cmd.delay  = i_in.initial_delay;

    assign fire_any = |fire_vec;
    assign step     = (r_state == S_TICK) && (!fire_any || !r_pend || out_free);

    assign beat_load = cmd.apply || (step && fire_any && r_pend)
                     || ((r_state == S_FLUSH) && out_free);

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        logic tok_in;
        if (k == 0) begin : g_head
            assign tok_in = start;
        end else begin : g_link
            assign tok_in = stat[k-1].tok;
        end

        ptts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(k)),
            .i_cmd   (cmd),
            .i_tok   (tok_in),
            .i_shift (step || start),
            .i_step  (step),
            .o_stat  (stat[k])
        );

        assign tok_vec[k]  = stat[k].tok;
        assign fire_vec[k] = stat[k].fire;
        assign hit_vec[k]  = stat[k].hit;
        assign occ_vec[k]  = stat[k].occ_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (beat_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.op == OP_TICK) begin
                            r_state <= S_TICK;
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                        end else begin
                            r_fired_slot <= i_in.task_slot;
                            r_last       <= 1'b1;
                            if (i_in.op == OP_CREATE) begin
                                r_status <= ((|hit_vec) && !(|occ_vec)) ? ST_CREATED
                                                                        : ST_TAKEN;
                            end else begin
                                r_status <= ST_DONE;
                            end
                        end
                    end
                end
                S_TICK: begin
                    if (step) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (fire_any) begin
                            if (r_pend) begin
                                r_status     <= ST_DUE;
                                r_fired_slot <= r_pend_slot;
                                r_last       <= 1'b0;
                            end
                            r_pend      <= 1'b1;
                            r_pend_slot <= r_idx[2:0];
                        end
                        if (tok_vec[NUM_SLOTS-1]) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_last       <= 1'b1;
                        r_status     <= r_pend ? ST_DUE : ST_NONE;
                        r_fired_slot <= r_pend ? r_pend_slot : 3'd0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.fired_slot  = r_fired_slot;
    assign o_out.last_result = r_last;

    // visit token is never duplicated
    `ASSERT_PROP(a_tok_onehot, i_clk, i_rst_n, $onehot0(tok_vec), "more than one visit token")
    `ASSERT_NEVER(a_idle_no_tok, i_clk, i_rst_n, (r_state == S_IDLE) && |tok_vec, "stray token")
    `ASSERT_PROP(a_cmd_beat, i_clk, i_rst_n, cmd.apply |=> r_out_valid, "command gave no beat")
    `ASSERT_PROP(a_tick_walk, i_clk, i_rst_n, start |=> tok_vec[0], "walk did not start")

endmodule

>>> dv/tb_periodic_task_tick_scheduler_core.sv
module tb_periodic_task_tick_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ptts_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 4 * NUM_SLOTS + 8;
    localparam int PHASES = 4;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int PLAN_LEN = 25;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [15:0] delay;
        logic        pinned;
        logic [2:0]  status;
        logic [2:0]  fired;
    } t_row;

    // pinned rows carry their own answer, the rest go through the predictor
    localparam t_row PLAN [PLAN_LEN] = '{
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b1, ST_NONE,    3'd0},
        '{OP_DELETE,   3'd5, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd5},
        '{OP_CREATE,   3'd0, 16'h0000, 16'h0000, 1'b1, ST_CREATED, 3'd0},
        '{OP_CREATE,   3'd0, 16'hFFFF, 16'hFFFF, 1'b1, ST_TAKEN,   3'd0},
        '{OP_CREATE,   3'd7, 16'hFFFF, 16'hFFFF, 1'b1, ST_CREATED, 3'd7},
        '{OP_CREATE,   3'd3, 16'h0001, 16'h0001, 1'b1, ST_CREATED, 3'd3},
        '{OP_CREATE,   3'd4, 16'h0002, 16'h0000, 1'b1, ST_CREATED, 3'd4},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_TICK,     3'd7, 16'hFFFF, 16'hFFFF, 1'b0, ST_DUE,     3'd0},
        '{OP_SUSPEND,  3'd4, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd4},
        '{OP_SUSPEND,  3'd6, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd6},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_RESUME,   3'd4, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd4},
        '{OP_RESUME,   3'd6, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd6},
        '{OP_DELETE,   3'd7, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd7},
        '{OP_CREATE,   3'd2, 16'h0003, 16'h0002, 1'b1, ST_CREATED, 3'd2},
        '{OP_DELETE,   3'd2, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd2},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0},
        '{OP_SPARE_LO, 3'd1, 16'h0000, 16'h0000, 1'b1, ST_DONE,    3'd1},
        '{OP_SPARE_HI, 3'd6, 16'hFFFF, 16'hFFFF, 1'b1, ST_DONE,    3'd6},
        '{OP_CREATE,   3'd5, 16'h0001, 16'h0000, 1'b1, ST_CREATED, 3'd5},
        '{OP_TICK,     3'd0, 16'h0000, 16'h0000, 1'b0, ST_DUE,     3'd0}
    };

    logic clk;
    logic rst_n;

    ptts_in_if  cmd_bus ();
    ptts_out_if res_bus ();

    periodic_task_tick_scheduler_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_bus),
        .o_out   (res_bus)
    );

    // scheduler shadow state
    logic        taken     [NUM_SLOTS];
    logic        parked    [NUM_SLOTS];
    logic [15:0] reload    [NUM_SLOTS];
    logic [15:0] remaining [NUM_SLOTS];

    t_beat step_beats [$];
    t_beat awaited    [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    function automatic void schedule_step(input logic [2:0] op, input logic [2:0] slot,
                                          input logic [15:0] per, input logic [15:0] dly);
        int    idx;
        t_beat tail;
        idx = int'(slot);
        step_beats.delete();
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!parked[i]) begin
                    if (remaining[i] != 16'd0) begin
                        remaining[i] = remaining[i] - 16'd1;
                    end else if (taken[i]) begin
                        step_beats.push_back('{ST_DUE, 3'(i), 1'b0});
                        remaining[i] = reload[i] - 16'd1;
                    end
                end
            end
            if (step_beats.size() == 0) begin
                step_beats.push_back('{ST_NONE, 3'd0, 1'b1});
            end else begin
                tail = step_beats.pop_back();
                tail.last = 1'b1;
                step_beats.push_back(tail);
            end
        end else if (op == OP_CREATE) begin
            if (idx < NUM_SLOTS && !taken[idx]) begin
                taken[idx]     = 1'b1;
                parked[idx]    = 1'b0;
                reload[idx]    = per;
                remaining[idx] = dly;
                step_beats.push_back('{ST_CREATED, slot, 1'b1});
            end else begin
                step_beats.push_back('{ST_TAKEN, slot, 1'b1});
            end
        end else begin
            if (idx < NUM_SLOTS) begin
                case (op)
                    OP_DELETE: begin
                        taken[idx] = 1'b0;
                    end
                    OP_SUSPEND: begin
                        parked[idx] = 1'b1;
                    end
                    OP_RESUME: begin
                        parked[idx] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            step_beats.push_back('{ST_DONE, slot, 1'b1});
        end
    endfunction

    task automatic flag(input string msg);
        if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic send_cmd(input logic [2:0] op, input logic [2:0] slot,
                            input logic [15:0] per, input logic [15:0] dly,
                            input logic pinned, input t_beat pinned_beat);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.op            <= op;
        cmd_bus.task_slot     <= slot;
        cmd_bus.period_ticks  <= per;
        cmd_bus.initial_delay <= dly;
        do @(posedge clk); while (cmd_bus.ready !== 1'b1);
        schedule_step(op, slot, per, dly);
        if (pinned) begin
            awaited.push_back(pinned_beat);
        end else begin
            foreach (step_beats[k]) awaited.push_back(step_beats[k]);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check each beat against the oldest expectation
    always @(posedge clk) begin
        t_beat want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected beat status %0d slot %0d",
                               res_bus.status, res_bus.fired_slot));
            end else begin
                want = awaited.pop_front();
                if (res_bus.status !== want.status)
                    flag($sformatf("status got %0d want %0d", res_bus.status, want.status));
                if (res_bus.fired_slot !== want.slot)
                    flag($sformatf("fired_slot got %0d want %0d",
                                   res_bus.fired_slot, want.slot));
                if (res_bus.last_result !== want.last)
                    flag($sformatf("last_result got %0d want %0d",
                                   res_bus.last_result, want.last));
            end
        end
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        int          phase_send  [PHASES];
        int          phase_stall [PHASES];
        int          pick;
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [15:0] per;
        logic [15:0] dly;
        phase_send  = '{0, 75, 0, 35};
        phase_stall = '{0, 0, 75, 35};
        for (int i = 0; i < NUM_SLOTS; i++) begin
            taken[i]     = 1'b0;
            parked[i]    = 1'b0;
            reload[i]    = 16'd0;
            remaining[i] = 16'd0;
        end
        rst_n                 <= 1'b0;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.op            <= OP_TICK;
        cmd_bus.task_slot     <= 3'd0;
        cmd_bus.period_ticks  <= 16'd0;
        cmd_bus.initial_delay <= 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            send_cmd(PLAN[r].op, PLAN[r].slot, PLAN[r].period, PLAN[r].delay,
                     PLAN[r].pinned, '{PLAN[r].status, PLAN[r].fired, 1'b1});
        end

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                slot = 3'($urandom_range(7));
                per  = 16'($urandom);
                dly  = 16'($urandom);
                if (pick < 50) begin
                    op = OP_TICK;
                end else if (pick < 70) begin
                    // mostly short periods and delays so tasks keep firing
                    op = OP_CREATE;
                    pick = $urandom_range(99);
                    if (pick < 90) per = 16'($urandom_range(1, 6));
                    else if (pick < 94) per = 16'd0;
                    if ($urandom_range(99) < 85) dly = 16'($urandom_range(0, 4));
                end else if (pick < 80) begin
                    op = OP_DELETE;
                end else if (pick < 88) begin
                    op = OP_SUSPEND;
                end else if (pick < 96) begin
                    op = OP_RESUME;
                end else begin
                    op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end
                send_cmd(op, slot, per, dly, 1'b0, '0);
            end
            // drain before the next idling pattern
            cmd_bus.valid <= 1'b0;
            while (awaited.size() != 0) @(posedge clk);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
